>>> src/msd_pkg.sv
// Shared constants, types and sequencer states for the multiword short divider.
package msd_pkg;

  localparam int WORD_W         = 32;
  localparam int DIGIT_BITS_DEF = 32;
  localparam int STEP_CNT_W     = $clog2(WORD_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_LOAD_MAIN,
    S_MAIN,
    S_WAIT
  } state_t;

  // Command from the sequencer to the shift-subtract core.
  typedef struct packed {
    logic                  load;
    logic [WORD_W-1:0]     rem_init;
    logic [WORD_W-1:0]     bits;
    logic [STEP_CNT_W-1:0] steps;
  } core_cmd_t;

  typedef struct packed {
    logic busy;
    logic last_step;
  } core_stat_t;

endpackage

>>> src/msd_if.sv
// Channel interfaces: dividend digits in, quotient words out.
interface msd_in_if;
  logic                        valid;
  logic                        ready;
  logic [msd_pkg::WORD_W-1:0]  digit;
  logic                        last_digit;

  modport source (output valid, output digit, output last_digit, input ready);
  modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

interface msd_out_if;
  logic                        valid;
  logic                        ready;
  logic [msd_pkg::WORD_W-1:0]  quotient_digit;
  logic [msd_pkg::WORD_W-1:0]  final_remainder;
  logic                        is_last;
  logic                        divide_by_zero;

  modport source (output valid, output quotient_digit, output final_remainder,
                  output is_last, output divide_by_zero, input ready);
  modport sink   (input valid, input quotient_digit, input final_remainder,
                  input is_last, input divide_by_zero, output ready);
endinterface

>>> src/msd_core.sv
// Radix-2 restoring shift-subtract core: one quotient bit per cycle.
module msd_core (
  input  logic                                clk,
  input  logic                                rst,
  input  msd_pkg::core_cmd_t                  cmd,
  input  logic [msd_pkg::WORD_W-1:0]          divisor,
  output msd_pkg::core_stat_t                 stat,
  output logic [msd_pkg::WORD_W-1:0]          rem,
  output logic [msd_pkg::WORD_W-1:0]          quo
);

  logic                              busy;
  logic [msd_pkg::STEP_CNT_W-1:0]    cnt;
  logic [msd_pkg::WORD_W-1:0]        bits;
  logic [msd_pkg::WORD_W:0]          trial;
  logic [msd_pkg::WORD_W:0]          diff;
  logic                              ge;

  // shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial = {rem, bits[msd_pkg::WORD_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.load) begin
      busy <= 1'b1;
      cnt  <= cmd.steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == msd_pkg::STEP_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem  <= cmd.rem_init;
      bits <= cmd.bits;
      quo  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[msd_pkg::WORD_W-1:0] : trial[msd_pkg::WORD_W-1:0];
      bits <= {bits[msd_pkg::WORD_W-2:0], 1'b0};
      quo  <= {quo[msd_pkg::WORD_W-2:0], ge};
    end
  end

  assign stat.busy      = busy;
  assign stat.last_step = busy && (cnt == msd_pkg::STEP_CNT_W'(1));

endmodule

>>> src/multiword_short_divider.sv
// Top level: sequencer, divisor and running remainder, output word register.
//
//  channel    dir  handshake      payload
//  dividend   in   valid/ready    digit[31:0], last_digit
//  quotient   out  valid/ready    quotient_digit, final_remainder, is_last,
//                                 divide_by_zero
//  cfg        in   cfg_we         cfg_data[31:0] -> divisor
//
// Each word runs DIGIT_BITS steps through the one-bit-per-cycle shift-subtract
// core before the next accept. If the running remainder is not below
// the divisor (divisor changed mid-dividend), a 32-step reduction pass runs
// first. A zero divisor skips the core and goes straight to the output wait.
// rst is synchronous: divisor returns to 1, running remainder to 0.
// A result waiting in the output register does not block the next accept; a
// second result waits in the core until the register frees.
module multiword_short_divider #(
  parameter int DIGIT_BITS = msd_pkg::DIGIT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  msd_in_if.sink                       dividend,
  msd_out_if.source                    quotient,
  input  logic                         cfg_we,
  input  logic [msd_pkg::WORD_W-1:0]   cfg_data
);

  localparam logic [msd_pkg::WORD_W-1:0] QMASK =
    msd_pkg::WORD_W'((64'd1 << DIGIT_BITS) - 64'd1);

  msd_pkg::state_t                 state;
  msd_pkg::state_t                 state_next;
  msd_pkg::core_cmd_t              cmd;
  msd_pkg::core_stat_t             core_stat;
  logic [msd_pkg::WORD_W-1:0]      core_rem;
  logic [msd_pkg::WORD_W-1:0]      core_quo;

  logic [msd_pkg::WORD_W-1:0]      divisor;
  logic [msd_pkg::WORD_W-1:0]      running_rem;
  logic [msd_pkg::WORD_W-1:0]      digit_q;
  logic                            last_q;
  logic                            dbz_q;
  logic                            sat_q;

  logic                            accept;
  logic                            dbz_now;
  logic                            rem_big;
  logic                            out_free;
  logic                            out_load;

  assign accept   = dividend.valid && dividend.ready;
  assign dbz_now  = divisor == '0;
  assign rem_big  = running_rem >= divisor;
  assign out_free = !quotient.valid || quotient.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      msd_pkg::S_IDLE: begin
        if (accept) begin
          if (dbz_now) begin
            state_next = msd_pkg::S_WAIT;
          end else if (rem_big) begin
            state_next = msd_pkg::S_PRE;
          end else begin
            state_next = msd_pkg::S_MAIN;
          end
        end
      end
      msd_pkg::S_PRE: begin
        if (core_stat.last_step) begin
          state_next = msd_pkg::S_LOAD_MAIN;
        end
      end
      msd_pkg::S_LOAD_MAIN: state_next = msd_pkg::S_MAIN;
      msd_pkg::S_MAIN: begin
        if (core_stat.last_step) begin
          state_next = msd_pkg::S_WAIT;
        end
      end
      msd_pkg::S_WAIT: begin
        if (out_free) begin
          state_next = msd_pkg::S_IDLE;
        end
      end
      default: state_next = msd_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd            = '0;
    dividend.ready = 1'b0;
    out_load       = 1'b0;
    unique case (state)
      msd_pkg::S_IDLE: begin
        dividend.ready = 1'b1;
        if (dividend.valid && !dbz_now) begin
          cmd.load = 1'b1;
          if (rem_big) begin
            // reduce the stale remainder modulo the divisor first
            cmd.rem_init = '0;
            cmd.bits     = running_rem;
            cmd.steps    = msd_pkg::STEP_CNT_W'(msd_pkg::WORD_W);
          end else begin
            cmd.rem_init = running_rem;
            cmd.bits     = dividend.digit << (msd_pkg::WORD_W - DIGIT_BITS);
            cmd.steps    = msd_pkg::STEP_CNT_W'(DIGIT_BITS);
          end
        end
      end
      msd_pkg::S_LOAD_MAIN: begin
        cmd.load     = 1'b1;
        cmd.rem_init = core_rem;
        cmd.bits     = digit_q << (msd_pkg::WORD_W - DIGIT_BITS);
        cmd.steps    = msd_pkg::STEP_CNT_W'(DIGIT_BITS);
      end
      msd_pkg::S_WAIT: out_load = out_free;
      msd_pkg::S_PRE, msd_pkg::S_MAIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= msd_pkg::S_IDLE;
      divisor       <= msd_pkg::WORD_W'(1);
      running_rem   <= '0;
      quotient.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        divisor <= cfg_data;
      end
      if (out_load) begin
        quotient.valid <= 1'b1;
        running_rem    <= (dbz_q || last_q) ? '0 : core_rem;
      end else if (quotient.ready) begin
        quotient.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      digit_q <= dividend.digit;
      last_q  <= dividend.last_digit;
      dbz_q   <= dbz_now;
      sat_q   <= rem_big;
    end
    if (out_load) begin
      quotient.quotient_digit  <= dbz_q ? '0 : (sat_q ? QMASK : (core_quo & QMASK));
      quotient.final_remainder <= (dbz_q || !last_q) ? '0 : core_rem;
      quotient.is_last         <= !dbz_q && last_q;
      quotient.divide_by_zero  <= dbz_q;
    end
  end

  msd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .divisor (divisor),
    .stat    (core_stat),
    .rem     (core_rem),
    .quo     (core_quo)
  );

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !core_stat.busy)
    else $error("core loaded while busy");

  a_step_state: assert property (@(posedge clk) disable iff (rst)
    core_stat.busy |-> (state == msd_pkg::S_PRE || state == msd_pkg::S_MAIN))
    else $error("core running outside a division pass");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    (state == msd_pkg::S_WAIT && !dbz_q) |-> core_rem < divisor)
    else $error("partial remainder not below divisor");

  a_out_word: assert property (@(posedge clk) disable iff (rst)
    out_load |=> quotient.valid && state == msd_pkg::S_IDLE)
    else $error("result word not presented");

endmodule

>>> dv/msd_checker.sv
// Quotient word checker: predicts each word from accepted digits and compares.
module msd_checker #(
  parameter int DIGIT_BITS = msd_pkg::DIGIT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  msd_in_if                           dividend,
  msd_out_if                          quotient,
  input  logic                        cfg_we,
  input  logic [msd_pkg::WORD_W-1:0]  cfg_data,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [msd_pkg::WORD_W-1:0] quotient_digit;
    logic [msd_pkg::WORD_W-1:0] final_remainder;
    logic                       is_last;
    logic                       divide_by_zero;
  } quot_word_t;

  localparam logic [63:0] DIGIT_MASK = (64'd1 << DIGIT_BITS) - 64'd1;

  logic [31:0] divisor_q;
  logic [31:0] carry_rem;
  quot_word_t  quot_words_due[$];

  // One short-division step on the running remainder.
  function automatic quot_word_t divide_word(input logic [31:0] digit, input logic last);
    quot_word_t  w;
    logic [63:0] v;
    logic [63:0] q;
    logic [63:0] r;
    w = '0;
    if (divisor_q == 32'd0) begin
      // in-progress dividend is dropped
      carry_rem = 32'd0;
      w.divide_by_zero = 1'b1;
      return w;
    end
    v = ({32'd0, carry_rem} << DIGIT_BITS) + ({32'd0, digit} & DIGIT_MASK);
    q = v / {32'd0, divisor_q};
    r = v % {32'd0, divisor_q};
    // remainder left over from a larger divisor can push q past one digit
    if (q > DIGIT_MASK) q = DIGIT_MASK;
    w.quotient_digit = q[31:0];
    if (last) begin
      w.final_remainder = r[31:0];
      w.is_last = 1'b1;
      carry_rem = 32'd0;
    end else begin
      carry_rem = r[31:0];
    end
    return w;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    quot_word_t want;
    if (rst) begin
      divisor_q = 32'd1;
      carry_rem = 32'd0;
      quot_words_due.delete();
    end else begin
      if (cfg_we) divisor_q = cfg_data;
      if (dividend.valid && dividend.ready)
        quot_words_due.push_back(divide_word(dividend.digit, dividend.last_digit));
      if (quotient.valid && quotient.ready) begin
        if (quot_words_due.size() == 0) begin
          $error("quotient word with none expected: quotient_digit %h",
                 quotient.quotient_digit);
          errors++;
        end else begin
          want = quot_words_due.pop_front();
          check_field("quotient_digit", want.quotient_digit, quotient.quotient_digit);
          check_field("final_remainder", want.final_remainder, quotient.final_remainder);
          check_field("is_last", {31'd0, want.is_last}, {31'd0, quotient.is_last});
          check_field("divide_by_zero", {31'd0, want.divide_by_zero},
                      {31'd0, quotient.divide_by_zero});
        end
      end
    end
    pending = quot_words_due.size();
  end

endmodule

>>> dv/tb_multiword_short_divider.sv
// Testbench top: clock, reset, digit stimulus, divisor writes, watchdog and verdict.
module tb_multiword_short_divider;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    GAP_NONE,
    GAP_SEND,
    GAP_RECV,
    GAP_BOTH
  } gap_mode_t;

  localparam int DIGIT_BITS     = msd_pkg::DIGIT_BITS_DEF;
  localparam int RANDOM_WORDS   = 1130;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles   = 0;
  int          digits_left    = 0;

  msd_in_if  dividend();
  msd_out_if quotient();

  multiword_short_divider #(.DIGIT_BITS(DIGIT_BITS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .dividend (dividend),
    .quotient (quotient),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  msd_checker #(.DIGIT_BITS(DIGIT_BITS)) u_checker (
    .clk      (clk),
    .rst      (rst),
    .dividend (dividend),
    .quotient (quotient),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    quotient.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Ends a hung run: too long without a word moving on either side.
  always @(posedge clk) begin
    if (rst || (dividend.valid && dividend.ready) || (quotient.valid && quotient.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void set_gap_mode(input gap_mode_t mode);
    case (mode)
      GAP_NONE: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      GAP_SEND: begin
        send_gap_pct   = 55;
        recv_stall_pct = 0;
      end
      GAP_RECV: begin
        send_gap_pct   = 0;
        recv_stall_pct = 55;
      end
      default: begin
        send_gap_pct   = 31;
        recv_stall_pct = 31;
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the accept.
  task automatic send_word(input logic [31:0] d, input logic last);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      dividend.valid <= 1'b0;
      @(negedge clk);
    end
    dividend.valid      <= 1'b1;
    dividend.digit      <= d;
    dividend.last_digit <= last;
    @(posedge clk);
    while (!dividend.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Divisor changes only once every quotient word is back.
  task automatic write_divisor(input logic [31:0] value);
    dividend.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_digit();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_divisor();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000 | $urandom;
      4, 5:    return $urandom_range(2, 255);
      6:       return $urandom_range(256, 65535);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int phase_no;
    int random_sent;
    int budget;
    int phase_words;
    bit phase_done;
    dividend.valid      = 1'b0;
    dividend.digit      = '0;
    dividend.last_digit = 1'b0;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    rst                 = 1'b1;
    phase_no            = 0;
    random_sent         = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    set_gap_mode(GAP_NONE);
    // divisor out of reset is 1: quotient equals the dividend
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    // largest divisor, remainder one below it
    write_divisor(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFE, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b1);
    // zero divisor abandons a dividend in progress
    write_divisor(32'd7);
    send_word(32'h1234_5678, 1'b0);
    write_divisor(32'd0);
    send_word(32'd5, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    write_divisor(32'd7);
    send_word(32'd9, 1'b1);
    // smaller divisor mid-dividend: quotient digit saturates
    write_divisor(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFE, 1'b0);
    write_divisor(32'd2);
    send_word(32'd1, 1'b0);
    send_word(32'd3, 1'b1);
    write_divisor(32'h8000_0000);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    write_divisor(32'd3);
    send_word(32'hAAAA_AAAA, 1'b0);
    send_word(32'h5555_5555, 1'b1);

    // Random dividends; a phase may end mid-dividend so the new divisor
    // applies to a remainder built under the old one.
    while (random_sent < RANDOM_WORDS) begin
      set_gap_mode(gap_mode_t'(phase_no % 4));
      phase_no++;
      write_divisor(rand_divisor());
      budget      = $urandom_range(15, 60);
      phase_words = 0;
      phase_done  = 1'b0;
      while (!phase_done) begin
        if (digits_left == 0) digits_left = $urandom_range(1, 6);
        send_word(rand_digit(), digits_left == 1);
        digits_left--;
        phase_words++;
        random_sent++;
        if (phase_words >= budget && (digits_left == 0 || $urandom_range(0, 3) == 0))
          phase_done = 1'b1;
      end
    end

    dividend.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> multiword_short_divider.f
src/msd_pkg.sv
src/msd_if.sv
src/msd_core.sv
src/multiword_short_divider.sv
dv/msd_checker.sv
dv/tb_multiword_short_divider.sv
